@@ rtl/i2c_poll_command_sequencer_core_macros.svh @@
// Assertion macros used by the checker file.
`ifndef I2C_POLL_COMMAND_SEQUENCER_CORE_MACROS_SVH
`define I2C_POLL_COMMAND_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sequencer assertion failed");

// Next-cycle implication, disabled during reset.
`define PCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequencer assertion failed");

`endif

@@ rtl/i2c_pcs_pkg.sv @@
`default_nettype none

package i2c_pcs_pkg;

   localparam int unsigned POLL_SLOTS    = 3;
   localparam int unsigned CMD_BUF_BYTES = 32;

   localparam logic [7:0] WATCHDOG_LIMIT_RESET = 8'd10;
   localparam logic [7:0] ERROR_LIMIT_RESET    = 8'd5;

   typedef enum logic [1:0] {
      EV_TICK       = 2'd0,
      EV_WRITE_DONE = 2'd1,
      EV_READ_DONE  = 2'd2,
      EV_SUBMIT     = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2,
      ACT_RESET = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_IDLE = 2'd0,
      KIND_POLL = 2'd1,
      KIND_CMD  = 2'd2
   } kind_type;

   typedef enum logic {
      CSR_WATCHDOG_LIMIT = 1'b0,
      CSR_ERROR_LIMIT    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0] command;
      logic       start_error;
      logic       xfer_ok;
      logic [6:0] cmd_dest;
      logic [5:0] cmd_len;
   } req_type;

   typedef struct packed {
      logic [1:0] action;
      logic [1:0] target_slot;
      logic [6:0] dest_addr;
      logic [5:0] write_len;
      logic [1:0] answer_slot;
      logic       answer_valid;
      logic       submit_accepted;
      logic [7:0] poll_cycles;
      logic [7:0] error_count;
      logic       busy_res;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/i2c_poll_command_sequencer_core.sv @@
// Channel   Direction  Handshake            Word
// req_      in         req_valid/req_ready  req_type: one event
// rsp_      out        rsp_valid/rsp_ready  rsp_type: one result per event
// csr_      in         csr_we               csr_index, csr_wdata (8 bits)
//
// One event a cycle; its result appears in the output register the cycle after acceptance.
// The scheduler state updates in the same cycle from one pass of logic over the state registers.
// req_ready stays high while the output register is empty or being taken this cycle.
// A stalled result holds the input side off until it is taken.
// Synchronous reset clears the state, the output valid and loads the register defaults.
`default_nettype none

module i2c_poll_command_sequencer_core
   import i2c_pcs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_we,
   input  wire logic    csr_index,
   input  wire logic [7:0] csr_wdata
);

   function automatic logic [2:0] slot_advance(input logic [1:0] slot, input logic [1:0] step);
      logic [2:0] sum;
      sum = {1'b0, slot} + {1'b0, step};
      if (sum >= 3'(POLL_SLOTS)) begin
         return 3'b100;
      end
      return {1'b0, sum[1:0]};
   endfunction

   logic [7:0] watchdog_limit_ff;
   logic [7:0] error_limit_ff;

   logic [1:0] slot_ff, slot_in;
   logic [7:0] rounds_ff, rounds_in;
   kind_type   kind_ff, kind_in;
   logic [7:0] errors_ff, errors_in;
   logic [7:0] wd_ff, wd_in;
   logic       waiting_ff, waiting_in;
   logic [6:0] addr_ff, addr_in;
   logic [5:0] bytes_ff, bytes_in;

   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic       accept;
   logic [7:0] wd_inc;
   logic [7:0] err_inc;
   logic       err_trip;
   logic [2:0] adv1, adv2;
   logic       slot_ok;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign wd_inc   = wd_ff + 8'd1;
   assign err_inc  = (errors_ff != 8'hFF) ? errors_ff + 8'd1 : errors_ff;
   assign err_trip = err_inc > error_limit_ff;
   assign adv1     = slot_advance(slot_ff, 2'd1);
   assign adv2     = slot_advance(slot_ff, 2'd2);
   assign slot_ok  = {1'b0, slot_ff} < 3'(POLL_SLOTS);

   always_comb begin
      slot_in     = slot_ff;
      rounds_in   = rounds_ff;
      kind_in     = kind_ff;
      errors_in   = errors_ff;
      wd_in       = wd_ff;
      waiting_in  = waiting_ff;
      addr_in     = addr_ff;
      bytes_in    = bytes_ff;
      rsp_data_in = '0;
      case (req_data.command)
         EV_TICK: begin
            wd_in = wd_inc;
            if (wd_inc == watchdog_limit_ff) begin
               if (kind_ff != KIND_CMD) begin
                  slot_in   = adv1[1:0];
                  rounds_in = rounds_ff + 8'(adv1[2]);
               end
               kind_in            = KIND_IDLE;
               errors_in          = '0;
               rsp_data_in.action = ACT_RESET;
            end else if (kind_ff == KIND_IDLE) begin
               wd_in = '0;
               if (waiting_ff) begin
                  kind_in               = KIND_CMD;
                  rsp_data_in.action    = ACT_WRITE;
                  rsp_data_in.dest_addr = addr_ff;
                  rsp_data_in.write_len = bytes_ff;
               end else if (slot_ok) begin
                  kind_in                 = KIND_POLL;
                  rsp_data_in.action      = ACT_READ;
                  rsp_data_in.target_slot = slot_ff;
               end else begin
                  slot_in = '0;
               end
               if ((waiting_ff || slot_ok) && req_data.start_error) begin
                  kind_in = KIND_IDLE;
                  if (err_trip) begin
                     errors_in               = '0;
                     rsp_data_in.action      = ACT_RESET;
                     rsp_data_in.target_slot = '0;
                     rsp_data_in.dest_addr   = '0;
                     rsp_data_in.write_len   = '0;
                  end else begin
                     errors_in = err_inc;
                  end
               end
            end
         end
         EV_WRITE_DONE: begin
            if (req_data.xfer_ok) begin
               if (kind_ff == KIND_POLL) begin
                  slot_in   = adv1[1:0];
                  rounds_in = rounds_ff + 8'(adv1[2]);
               end else begin
                  waiting_in = 1'b0;
                  bytes_in   = '0;
               end
            end else begin
               if (err_trip) begin
                  errors_in          = '0;
                  rsp_data_in.action = ACT_RESET;
               end else begin
                  errors_in = err_inc;
               end
               if (kind_ff == KIND_POLL) begin
                  slot_in   = adv2[1:0];
                  rounds_in = rounds_ff + 8'(adv2[2]);
               end
            end
            kind_in = KIND_IDLE;
         end
         EV_READ_DONE: begin
            rsp_data_in.answer_slot = slot_ff;
            if (kind_ff == KIND_POLL) begin
               slot_in   = adv1[1:0];
               rounds_in = rounds_ff + 8'(adv1[2]);
            end
            kind_in = KIND_IDLE;
            if (req_data.xfer_ok) begin
               rsp_data_in.answer_valid = 1'b1;
            end else if (err_trip) begin
               errors_in          = '0;
               rsp_data_in.action = ACT_RESET;
            end else begin
               errors_in = err_inc;
            end
         end
         EV_SUBMIT: begin
            if (!waiting_ff && req_data.cmd_len != '0
                && {3'b000, req_data.cmd_len} <= 9'(CMD_BUF_BYTES)) begin
               waiting_in                  = 1'b1;
               addr_in                     = req_data.cmd_dest;
               bytes_in                    = req_data.cmd_len;
               rsp_data_in.submit_accepted = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rsp_data_in.poll_cycles = rounds_in;
      rsp_data_in.error_count = errors_in;
      rsp_data_in.busy_res    = kind_in != KIND_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         watchdog_limit_ff <= WATCHDOG_LIMIT_RESET;
         error_limit_ff    <= ERROR_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WATCHDOG_LIMIT: watchdog_limit_ff <= csr_wdata;
            CSR_ERROR_LIMIT:    error_limit_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         rounds_ff  <= '0;
         kind_ff    <= KIND_IDLE;
         errors_ff  <= '0;
         wd_ff      <= '0;
         waiting_ff <= 1'b0;
         addr_ff    <= '0;
         bytes_ff   <= '0;
      end else if (accept) begin
         slot_ff    <= slot_in;
         rounds_ff  <= rounds_in;
         kind_ff    <= kind_in;
         errors_ff  <= errors_in;
         wd_ff      <= wd_in;
         waiting_ff <= waiting_in;
         addr_ff    <= addr_in;
         bytes_ff   <= bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/i2c_pcs_checker.sv @@
`default_nettype none
`include "i2c_poll_command_sequencer_core_macros.svh"

module i2c_pcs_checker
   import i2c_pcs_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   `PCS_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready,
      req_valid && $stable(req_data))

   `PCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data))

   `PCS_ASSERT_NOW(a_ready_when_free, clock, reset, !rsp_valid, req_ready)

   `PCS_ASSERT_NEXT(a_word_follows, clock, reset, req_valid && req_ready, rsp_valid)

   `PCS_ASSERT_NOW(a_write_fields, clock, reset,
      rsp_valid && rsp_data.action != ACT_WRITE,
      rsp_data.dest_addr == '0 && rsp_data.write_len == '0)

endmodule

bind i2c_poll_command_sequencer_core i2c_pcs_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
   import i2c_pcs_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 400000;
   localparam int unsigned HOLD_CYCLES  = 200;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_data;
   logic       csr_we;
   logic       csr_index;
   logic [7:0] csr_wdata;

   // scheduler shadow state
   logic [7:0] cfg_wd_limit;
   logic [7:0] cfg_err_limit;
   logic [1:0] pred_slot;
   logic [7:0] pred_rounds;
   kind_type   pred_kind;
   logic [7:0] pred_errors;
   logic [7:0] pred_wd;
   logic       pred_cmd_pending;
   logic [6:0] pred_cmd_addr;
   logic [5:0] pred_cmd_len;

   rsp_type     sched_result_q[$];
   rsp_type     head_result;
   int unsigned err_cnt;
   int unsigned cycle_cnt;
   bit          idle_en;
   bit          rsp_hold_req;

   i2c_poll_command_sequencer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic void advance_poll(int unsigned step);
      int unsigned s;
      s = pred_slot + step;
      if (s >= POLL_SLOTS) begin
         s = 0;
         pred_rounds = pred_rounds + 8'd1;
      end
      pred_slot = s[1:0];
   endfunction

   function automatic bit count_fault();
      if (pred_errors != 8'hFF)
         pred_errors = pred_errors + 8'd1;
      if (pred_errors > cfg_err_limit) begin
         pred_errors = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void predict_schedule(req_type w);
      rsp_type r;
      r = '0;
      case (event_type'(w.command))
         EV_TICK: begin
            pred_wd = pred_wd + 8'd1;
            if (pred_wd == cfg_wd_limit) begin
               if (pred_kind != KIND_CMD)
                  advance_poll(1);
               pred_kind   = KIND_IDLE;
               pred_errors = '0;
               r.action    = ACT_RESET;
            end else if (pred_kind == KIND_IDLE) begin
               pred_wd = '0;
               if (pred_cmd_pending) begin
                  pred_kind   = KIND_CMD;
                  r.action    = ACT_WRITE;
                  r.dest_addr = pred_cmd_addr;
                  r.write_len = pred_cmd_len;
               end else if (pred_slot < POLL_SLOTS) begin
                  pred_kind     = KIND_POLL;
                  r.action      = ACT_READ;
                  r.target_slot = pred_slot;
               end else begin
                  pred_slot = '0;
               end
               if (r.action != ACT_NONE && w.start_error) begin
                  pred_kind = KIND_IDLE;
                  if (count_fault()) begin
                     r.action      = ACT_RESET;
                     r.target_slot = '0;
                     r.dest_addr   = '0;
                     r.write_len   = '0;
                  end
               end
            end
         end
         EV_WRITE_DONE: begin
            if (w.xfer_ok) begin
               if (pred_kind == KIND_POLL) begin
                  advance_poll(1);
               end else begin
                  pred_cmd_pending = 1'b0;
                  pred_cmd_len     = '0;
               end
            end else begin
               if (count_fault())
                  r.action = ACT_RESET;
               if (pred_kind == KIND_POLL)
                  advance_poll(2);
            end
            pred_kind = KIND_IDLE;
         end
         EV_READ_DONE: begin
            r.answer_slot = pred_slot;
            if (pred_kind == KIND_POLL)
               advance_poll(1);
            pred_kind = KIND_IDLE;
            if (w.xfer_ok)
               r.answer_valid = 1'b1;
            else if (count_fault())
               r.action = ACT_RESET;
         end
         default: begin
            if (!pred_cmd_pending && w.cmd_len != 0 && w.cmd_len <= CMD_BUF_BYTES) begin
               pred_cmd_pending  = 1'b1;
               pred_cmd_addr     = w.cmd_dest;
               pred_cmd_len      = w.cmd_len;
               r.submit_accepted = 1'b1;
            end
         end
      endcase
      r.poll_cycles = pred_rounds;
      r.error_count = pred_errors;
      r.busy_res    = (pred_kind != KIND_IDLE);
      sched_result_q.push_back(r);
   endfunction

   function automatic void field_check(string fname, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
         err_cnt++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (sched_result_q.size() == 0) begin
            $display("%0t: unexpected word, expected none actual %p", $time, rsp_data);
            err_cnt++;
         end else begin
            head_result = sched_result_q.pop_front();
            field_check("action", 32'(head_result.action), 32'(rsp_data.action));
            field_check("target_slot", 32'(head_result.target_slot),
                        32'(rsp_data.target_slot));
            field_check("dest_addr", 32'(head_result.dest_addr), 32'(rsp_data.dest_addr));
            field_check("write_len", 32'(head_result.write_len), 32'(rsp_data.write_len));
            field_check("answer_slot", 32'(head_result.answer_slot),
                        32'(rsp_data.answer_slot));
            field_check("answer_valid", 32'(head_result.answer_valid),
                        32'(rsp_data.answer_valid));
            field_check("submit_accepted", 32'(head_result.submit_accepted),
                        32'(rsp_data.submit_accepted));
            field_check("poll_cycles", 32'(head_result.poll_cycles),
                        32'(rsp_data.poll_cycles));
            field_check("error_count", 32'(head_result.error_count),
                        32'(rsp_data.error_count));
            field_check("busy_res", 32'(head_result.busy_res), 32'(rsp_data.busy_res));
         end
      end
   end

   // hold off on request, otherwise random stall bursts when idle_en is set
   initial begin : rsp_sink
      int unsigned gap;
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_hold_req = 1'b0;
            rsp_ready <= 1'b1;
         end else if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_word(req_type w);
      int unsigned gap;
      @(negedge clock);
      if (idle_en && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do
         @(posedge clock);
      while (!req_ready);
      predict_schedule(w);
   endtask

   task automatic send_event(event_type ev, logic se, logic ok, logic [6:0] dest,
                             logic [5:0] len);
      req_type w;
      w.command     = ev;
      w.start_error = se;
      w.xfer_ok     = ok;
      w.cmd_dest    = dest;
      w.cmd_len     = len;
      send_word(w);
   endtask

   function automatic req_type rand_word(event_type ev);
      req_type w;
      w.command     = ev;
      w.start_error = 1'($urandom_range(0, 1));
      w.xfer_ok     = 1'($urandom_range(0, 1));
      w.cmd_dest    = 7'($urandom_range(0, 127));
      if ($urandom_range(0, 9) == 0)
         w.cmd_len = 6'($urandom_range(0, 63));
      else
         w.cmd_len = 6'($urandom_range(1, 32));
      return w;
   endfunction

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sched_result_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_WATCHDOG_LIMIT)
         cfg_wd_limit = value;
      else
         cfg_err_limit = value;
   endtask

   task automatic set_limits(logic [7:0] wd_limit, logic [7:0] err_limit);
      drain();
      write_reg(CSR_WATCHDOG_LIMIT, wd_limit);
      write_reg(CSR_ERROR_LIMIT, err_limit);
   endtask

   task automatic test_directed();
      send_event(EV_TICK, 1'b0, 1'b0, 7'd0, 6'd1);
      send_event(EV_READ_DONE, 1'b0, 1'b1, 7'd0, 6'd1);
      send_event(EV_TICK, 1'b1, 1'b0, 7'd0, 6'd1);
      send_event(EV_SUBMIT, 1'b0, 1'b0, 7'd127, 6'd32);
      send_event(EV_SUBMIT, 1'b0, 1'b0, 7'd5, 6'd3);
      send_event(EV_TICK, 1'b0, 1'b0, 7'd0, 6'd0);
      send_event(EV_WRITE_DONE, 1'b0, 1'b1, 7'd0, 6'd0);
      send_event(EV_SUBMIT, 1'b1, 1'b1, 7'd0, 6'd0);
      send_event(EV_SUBMIT, 1'b0, 1'b0, 7'd1, 6'd33);
      send_event(EV_SUBMIT, 1'b0, 1'b0, 7'd2, 6'd63);
      send_event(EV_SUBMIT, 1'b0, 1'b0, 7'd0, 6'd1);
      send_event(EV_TICK, 1'b1, 1'b0, 7'd0, 6'd0);
      send_event(EV_TICK, 1'b0, 1'b0, 7'd0, 6'd0);
      send_event(EV_WRITE_DONE, 1'b0, 1'b0, 7'd0, 6'd0);
      send_event(EV_WRITE_DONE, 1'b0, 1'b1, 7'd0, 6'd0);
      send_event(EV_TICK, 1'b0, 1'b0, 7'd0, 6'd0);
      send_event(EV_WRITE_DONE, 1'b0, 1'b0, 7'd0, 6'd0);
      send_event(EV_TICK, 1'b0, 1'b0, 7'd0, 6'd0);
      send_event(EV_READ_DONE, 1'b0, 1'b0, 7'd0, 6'd0);
      send_event(EV_READ_DONE, 1'b1, 1'b1, 7'd0, 6'd0);
   endtask

   task automatic test_limits();
      set_limits(8'd2, 8'd0);
      send_event(EV_TICK, 1'b0, 1'b0, 7'd0, 6'd0);
      send_event(EV_TICK, 1'b0, 1'b0, 7'd0, 6'd0);
      send_event(EV_TICK, 1'b0, 1'b0, 7'd0, 6'd0);
      send_event(EV_TICK, 1'b0, 1'b0, 7'd0, 6'd0);
      send_event(EV_SUBMIT, 1'b0, 1'b0, 7'd85, 6'd21);
      send_event(EV_READ_DONE, 1'b0, 1'b1, 7'd0, 6'd0);
      send_event(EV_TICK, 1'b0, 1'b0, 7'd0, 6'd0);
      send_event(EV_TICK, 1'b0, 1'b0, 7'd0, 6'd0);
      send_event(EV_TICK, 1'b0, 1'b0, 7'd0, 6'd0);
      send_event(EV_TICK, 1'b1, 1'b0, 7'd0, 6'd0);
      send_event(EV_TICK, 1'b0, 1'b0, 7'd0, 6'd0);
      send_event(EV_WRITE_DONE, 1'b0, 1'b0, 7'd0, 6'd0);
      send_event(EV_TICK, 1'b0, 1'b0, 7'd0, 6'd0);
      send_event(EV_READ_DONE, 1'b0, 1'b0, 7'd0, 6'd0);
      set_limits(8'd1, 8'd255);
      repeat (6) send_event(EV_TICK, 1'b0, 1'b0, 7'd0, 6'd0);
   endtask

   task automatic test_error_saturation();
      req_type w;
      set_limits(8'd255, 8'd255);
      repeat (280) begin
         w = rand_word($urandom_range(0, 1) ? EV_WRITE_DONE : EV_READ_DONE);
         w.xfer_ok = 1'b0;
         send_word(w);
      end
   endtask

   // mostly tick / completion pairs, with noise and lost completions
   task automatic random_traffic(int unsigned n_words);
      req_type w;
      int unsigned sent;
      int unsigned extra;
      sent = 0;
      while (sent < n_words) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               w = rand_word(event_type'($urandom_range(0, 3)));
               send_word(w);
               sent++;
            end
            2: begin
               send_word(rand_word(EV_SUBMIT));
               sent++;
            end
            default: begin
               w = rand_word(EV_TICK);
               w.start_error = ($urandom_range(0, 9) == 0);
               send_word(w);
               sent++;
               if ($urandom_range(0, 7) == 0) begin
                  extra = $urandom_range(1, 12);
                  repeat (extra) send_word(rand_word(EV_TICK));
                  sent += extra;
               end else if (pred_kind != KIND_IDLE) begin
                  if (pred_kind == KIND_POLL && $urandom_range(0, 6) != 0)
                     w = rand_word(EV_READ_DONE);
                  else
                     w = rand_word(EV_WRITE_DONE);
                  w.xfer_ok = ($urandom_range(0, 4) != 0);
                  send_word(w);
                  sent++;
               end
            end
         endcase
      end
   endtask

   task automatic test_random_limits();
      set_limits(8'd10, 8'd5);
      random_traffic(200);
      set_limits(8'd1, 8'd0);
      random_traffic(150);
      set_limits(8'd255, 8'd255);
      random_traffic(150);
      set_limits(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
      random_traffic(150);
   endtask

   task automatic test_backpressure();
      set_limits(8'd6, 8'd3);
      idle_en      = 1'b0;
      rsp_hold_req = 1'b1;
      random_traffic(60);
      idle_en = 1'b1;
   endtask

   task automatic test_streaming();
      set_limits(8'd4, 8'd3);
      idle_en = 1'b0;
      random_traffic(200);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_we           = 1'b0;
      csr_index        = 1'b0;
      csr_wdata        = '0;
      idle_en          = 1'b1;
      rsp_hold_req     = 1'b0;
      cfg_wd_limit     = WATCHDOG_LIMIT_RESET;
      cfg_err_limit    = ERROR_LIMIT_RESET;
      pred_slot        = '0;
      pred_rounds      = '0;
      pred_kind        = KIND_IDLE;
      pred_errors      = '0;
      pred_wd          = '0;
      pred_cmd_pending = 1'b0;
      pred_cmd_addr    = '0;
      pred_cmd_len     = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_limits();
      test_error_saturation();
      test_random_limits();
      test_backpressure();
      test_streaming();
      drain();

      if (err_cnt == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
